// ===== src/kvt_pkg.sv =====
// Shared types and constants of the key/value table.
`default_nettype none

package kvt_pkg;

	localparam int unsigned ENTRIES     = 16;
	localparam int unsigned KEY_BYTES   = 8;
	localparam int unsigned VALUE_BYTES = 8;
	localparam int unsigned WORD_W      = 64;
	localparam int unsigned IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		FN_PUT = 2'd0,
		FN_GET = 2'd1,
		FN_DEL = 2'd2,
		FN_CLR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// Lookup item walking down the cell row.
	typedef struct packed {
		logic              vld;
		func_t             func;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] value;
		logic              hit;
		logic [WORD_W-1:0] rd_value;
		logic              free_seen;
		logic [IDX_W-1:0]  free_idx;
	} tok_t;

	// Write of a new entry into the lowest free cell after a put misses.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] value;
	} claim_t;

endpackage

`default_nettype wire

// ===== src/kvt_cell.sv =====
// One table entry: key, value and valid bit, plus one stage of the lookup chain.
`default_nettype none

module kvt_cell
	import kvt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire tok_t             tok_in,
	input  wire claim_t           claim,
	output tok_t                  tok_out
);

	logic              valid_q;
	logic [WORD_W-1:0] key_q;
	logic [WORD_W-1:0] value_q;
	logic              tok_vld_q;
	tok_t              tok_q;
	tok_t              nxt;
	logic              match;
	logic              claim_hit;

	assign claim_hit = claim.en && (claim.idx == idx);

	always_comb begin
		// earlier cells win on duplicate keys
		match = tok_in.vld && valid_q && !tok_in.hit && (key_q == tok_in.key);
		nxt   = tok_in;
		if (match) begin
			nxt.hit = 1'b1;
			if (tok_in.func == FN_GET) begin
				nxt.rd_value = value_q;
			end
		end
		if (tok_in.vld && !valid_q && !tok_in.free_seen) begin
			nxt.free_seen = 1'b1;
			nxt.free_idx  = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
			if (tok_in.vld && tok_in.func == FN_CLR) begin
				valid_q <= 1'b0;
			end else if (match && tok_in.func == FN_DEL) begin
				valid_q <= 1'b0;
			end else if (claim_hit) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
		if (match && tok_in.func == FN_PUT) begin
			value_q <= tok_in.value;
		end else if (claim_hit) begin
			key_q   <= claim.key;
			value_q <= claim.value;
		end
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = tok_vld_q;
	end

endmodule

`default_nettype wire

// ===== src/key_value_table_core.sv =====
// Top level of the key/value table: launch, cell row and result register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------
//   command  | start / busy              | func, key, value
//   result   | done (one-cycle strobe)   | status, value_out
//
// An item passes the launch register, one register per cell as the lookup walks
// the row, and the result register, which is loaded as a new entry is written.
// busy stays high from acceptance until the cycle done is raised.
// Reset clears all valid bits at once; keys and values need no clearing.
// The receiver cannot stall; done is a single-cycle strobe.
`default_nettype none

module key_value_table_core
	import kvt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        func,
	input  wire logic [WORD_W-1:0] key,
	input  wire logic [WORD_W-1:0] value,
	output logic                   done,
	output logic [1:0]             status,
	output logic [WORD_W-1:0]      value_out
);

	// Clear every byte after the first zero byte or beyond nbytes.
	function automatic logic [WORD_W-1:0] norm_str(input logic [WORD_W-1:0] w,
		input int unsigned nbytes);
		logic [WORD_W-1:0] kept;
		logic              live;
		kept = '0;
		live = 1'b1;
		for (int unsigned i = 0; i < WORD_W / 8; i++) begin
			if (i >= nbytes || w[8*i +: 8] == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				kept[8*i +: 8] = w[8*i +: 8];
			end
		end
		return kept;
	endfunction

	logic              busy_q;
	logic              launch_vld_q;
	tok_t              launch_q;
	logic              done_q;
	status_t           status_q;
	logic [WORD_W-1:0] value_out_q;
	tok_t              chain [ENTRIES+1];
	logic [ENTRIES:0]  tok_vld_vec;
	tok_t              tail;
	claim_t            claim;
	status_t           res_status;
	logic [WORD_W-1:0] res_value;
	logic              accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			launch_vld_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			launch_vld_q <= accept;
			done_q       <= tail.vld;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			launch_q.func      <= func_t'(func);
			launch_q.key       <= norm_str(key, KEY_BYTES);
			launch_q.value     <= norm_str(value, VALUE_BYTES);
			launch_q.hit       <= 1'b0;
			launch_q.rd_value  <= '0;
			launch_q.free_seen <= 1'b0;
			launch_q.free_idx  <= '0;
			launch_q.vld       <= 1'b1;
		end
		if (tail.vld) begin
			status_q    <= res_status;
			value_out_q <= res_value;
		end
	end

	always_comb begin
		chain[0]     = launch_q;
		chain[0].vld = launch_vld_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kvt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.tok_in  (chain[i]),
			.claim   (claim),
			.tok_out (chain[i+1])
		);
	end

	for (genvar i = 0; i <= ENTRIES; i++) begin : g_vld
		assign tok_vld_vec[i] = chain[i].vld;
	end

	assign tail = chain[ENTRIES];

	always_comb begin
		claim.en    = tail.vld && tail.func == FN_PUT && !tail.hit && tail.free_seen;
		claim.idx   = tail.free_idx;
		claim.key   = tail.key;
		claim.value = tail.value;
		res_value   = '0;
		unique case (tail.func)
			FN_PUT: res_status = (tail.hit || tail.free_seen) ? ST_OK : ST_FULL;
			FN_GET: begin
				res_status = tail.hit ? ST_OK : ST_MISS;
				if (tail.hit) begin
					res_value = tail.rd_value;
				end
			end
			FN_DEL: res_status = tail.hit ? ST_OK : ST_MISS;
			FN_CLR: res_status = ST_OK;
			default: res_status = ST_OK;
		endcase
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_out_q;

	// only one item is ever in the row
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld_vec) <= 1)
		else $error("more than one item in the cell row");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without a preceding busy period");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && launch_vld_q)
		else $error("accepted item not launched");

	a_full_on_put: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == ST_FULL |-> $past(tail.func == FN_PUT))
		else $error("full reported for an item other than put");

	a_value_on_get: assert property (@(posedge clk) disable iff (!arst_n)
		done && value_out != '0 |-> $past(tail.func == FN_GET && tail.hit))
		else $error("value returned for an item other than a hit get");

endmodule

`default_nettype wire
